[rtl/smix_pkg.sv]
package smix_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  localparam int SAMPLE_W    = 16;
  localparam int MIX_W       = SAMPLE_W + 2;
  localparam int BLEN_W      = 13;
  localparam int SIL_W       = 12;
  localparam int FILL_W      = 13;
  localparam int CMP_W       = (CNT_W > BLEN_W) ? CNT_W : BLEN_W;

  localparam logic signed [MIX_W-1:0] MIX_MAX = 18'sd32767;
  localparam logic signed [MIX_W-1:0] MIX_MIN = -18'sd32768;

  // Stream payload widths; the tdata widths are padded to whole bytes.
  localparam int S_DATA_W = 48;
  localparam int S_USER_W = 3;
  localparam int M_DATA_W = 32;
  localparam int M_USER_W = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_SILENCE = 1'b1;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_PULL  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t                        command;
    logic                        block_first;
    logic signed [SAMPLE_W-1:0]  mix;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  out_sample;
    logic                        underflow;
    logic                        push_taken;
    logic [FILL_W-1:0]           fill_level;
  } result_t;

endpackage

[rtl/smix_sat_add.sv]
module smix_sat_add (
  input  logic signed [smix_pkg::SAMPLE_W-1:0] wave_sample,
  input  logic signed [smix_pkg::SAMPLE_W-1:0] pcm_sample,
  input  logic signed [smix_pkg::SAMPLE_W-1:0] fm_sample,
  output logic signed [smix_pkg::SAMPLE_W-1:0] mix
);
  import smix_pkg::*;

  logic signed [MIX_W-1:0] sum;

  always_comb begin
    sum = MIX_W'(wave_sample) + MIX_W'(pcm_sample) + MIX_W'(fm_sample);
    if (sum > MIX_MAX) begin
      mix = MIX_MAX[SAMPLE_W-1:0];
    end else if (sum < MIX_MIN) begin
      mix = MIX_MIN[SAMPLE_W-1:0];
    end else begin
      mix = sum[SAMPLE_W-1:0];
    end
  end

endmodule

[rtl/smix_ring.sv]
module smix_ring (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  smix_pkg::item_t               item,
  input  logic [smix_pkg::BLEN_W-1:0]   block_length,
  input  logic [smix_pkg::SIL_W-1:0]    lead_silence,
  output smix_pkg::result_t             result
);
  import smix_pkg::*;

  logic [SAMPLE_W-1:0] store [STORE_DEPTH];

  logic [IDX_W-1:0] write_index, write_index_next;
  logic [IDX_W-1:0] read_index, read_index_next;
  logic [CNT_W-1:0] held_count, held_count_next;
  logic [CNT_W-1:0] silence_left, silence_left_next;
  logic             block_admitted, block_admitted_next;

  logic             do_write;
  logic             do_read;
  logic             underflow_next;
  logic             push_taken_next;
  logic [CNT_W-1:0] space;
  logic [CNT_W-1:0] lead_sat;
  logic             admit;

  always_comb begin
    space    = CNT_W'(STORE_DEPTH) - held_count;
    lead_sat = (CMP_W'(lead_silence) > CMP_W'(STORE_DEPTH)) ? CNT_W'(STORE_DEPTH)
                                                            : CNT_W'(lead_silence);

    write_index_next    = write_index;
    read_index_next     = read_index;
    held_count_next     = held_count;
    silence_left_next   = silence_left;
    block_admitted_next = block_admitted;
    do_write            = 1'b0;
    do_read             = 1'b0;
    underflow_next      = 1'b0;
    push_taken_next     = 1'b0;
    admit               = block_admitted;

    case (item.command)
      CMD_PUSH: begin
        // The first beat of a block decides whether the whole block fits.
        if (item.block_first) begin
          admit = CMP_W'(space) >= CMP_W'(block_length);
        end
        block_admitted_next = admit;
        if (admit && (held_count != CNT_W'(STORE_DEPTH))) begin
          do_write         = 1'b1;
          push_taken_next  = 1'b1;
          held_count_next  = held_count + 1'b1;
          write_index_next = (write_index == IDX_W'(STORE_DEPTH - 1)) ? '0
                                                                      : write_index + 1'b1;
        end
      end
      CMD_PULL: begin
        if (silence_left != '0) begin
          silence_left_next = silence_left - 1'b1;
          held_count_next   = held_count - 1'b1;
        end else if (held_count != '0) begin
          do_read         = 1'b1;
          held_count_next = held_count - 1'b1;
          read_index_next = (read_index == IDX_W'(STORE_DEPTH - 1)) ? '0
                                                                    : read_index + 1'b1;
        end else begin
          underflow_next = 1'b1;
        end
      end
      CMD_CLEAR: begin
        write_index_next    = '0;
        read_index_next     = '0;
        silence_left_next   = lead_sat;
        held_count_next     = lead_sat;
        block_admitted_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index    <= '0;
      read_index     <= '0;
      held_count     <= '0;
      silence_left   <= '0;
      block_admitted <= 1'b0;
    end else if (step) begin
      write_index    <= write_index_next;
      read_index     <= read_index_next;
      held_count     <= held_count_next;
      silence_left   <= silence_left_next;
      block_admitted <= block_admitted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && do_write) begin
      store[write_index] <= item.mix;
    end
  end

  // The store's read register doubles as the result sample register.
  always_ff @(posedge clk) begin
    if (step) begin
      if (do_read) begin
        result.out_sample <= store[read_index];
      end else begin
        result.out_sample <= '0;
      end
      result.underflow  <= underflow_next;
      result.push_taken <= push_taken_next;
      result.fill_level <= FILL_W'(held_count_next);
    end
  end

endmodule

[rtl/saturating_audio_mixer_ring_fifo_top.sv]
// Channel  | Dir | Handshake          | Payload
// s_*      | in  | s_tvalid/s_tready  | tdata: wave, pcm, fm; tuser: command, block_first
// m_*      | out | m_tvalid/m_tready  | tdata: out_sample, fill_level; tuser: underflow,
//          |     |                    |   push_taken
// cfg_*    | in  | cfg_we             | cfg_index, cfg_data
//
// One beat in, one beat out; a new beat is taken every cycle while the output drains.
// The path is an input register, then the mix, pointer and count update,
// with the store's registered read port feeding the result register.
// rst is synchronous and empties both stages; the store itself is not cleared.
// A stall on m_tready holds the result and backs up into s_tready through one stage.
module saturating_audio_mixer_ring_fifo_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [15:0] wave_sample, [31:16] pcm_sample, [47:32] fm_sample
  input  logic [smix_pkg::S_DATA_W-1:0]     s_tdata,
  // [1:0] command, [2] block_first
  input  logic [smix_pkg::S_USER_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [15:0] out_sample, [28:16] fill_level, [31:29] zero
  output logic [smix_pkg::M_DATA_W-1:0]     m_tdata,
  // [0] underflow, [1] push_taken
  output logic [smix_pkg::M_USER_W-1:0]     m_tuser,
  input  logic                              cfg_we,
  input  logic [smix_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [smix_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import smix_pkg::*;

  logic                       in_valid;
  logic [1:0]                 in_command;
  logic                       in_first;
  logic signed [SAMPLE_W-1:0] in_wave;
  logic signed [SAMPLE_W-1:0] in_pcm;
  logic signed [SAMPLE_W-1:0] in_fm;
  logic signed [SAMPLE_W-1:0] mix;
  logic                       advance;
  item_t                      item;
  result_t                    result;
  logic [BLEN_W-1:0]          block_length;
  logic [SIL_W-1:0]           lead_silence;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_command <= s_tuser[1:0];
      in_first   <= s_tuser[2];
      in_wave    <= s_tdata[15:0];
      in_pcm     <= s_tdata[31:16];
      in_fm      <= s_tdata[47:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= BLEN_W'(1024);
      lead_silence <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_LENGTH: block_length <= cfg_data[BLEN_W-1:0];
        REG_LEAD_SILENCE: lead_silence <= cfg_data[SIL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  smix_sat_add u_sat_add (
    .wave_sample (in_wave),
    .pcm_sample  (in_pcm),
    .fm_sample   (in_fm),
    .mix         (mix)
  );

  assign item.command     = cmd_t'(in_command);
  assign item.block_first = in_first;
  assign item.mix         = mix;

  smix_ring u_ring (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .item         (item),
    .block_length (block_length),
    .lead_silence (lead_silence),
    .result       (result)
  );

  assign m_tdata = {3'b000, result.fill_level, result.out_sample};
  assign m_tuser = {result.push_taken, result.underflow};

endmodule

[rtl/smix_checker.sv]
module smix_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [smix_pkg::M_DATA_W-1:0]     m_tdata,
  input logic [smix_pkg::M_USER_W-1:0]     m_tuser
);

  // An empty store on a pull means nothing was held, so the level must read zero too.
  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[15:0] == 16'd0) && (m_tdata[28:16] == 13'd0))
    else $error("underflow beat with nonzero sample or fill level");

  a_push_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0] && (m_tdata[28:16] != 13'd0))
    else $error("taken push reports underflow or an empty store");

  a_out_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind saturating_audio_mixer_ring_fifo_top smix_checker u_smix_checker (.*);
